/* design/rhn_pkg.sv */
// ---------------------------------------------------------------------------
// rhn_pkg - shared definitions for the random hue noise pixel generator
// Matrix geometry, generator constants, hue region codes and the xorshift step.
// ---------------------------------------------------------------------------
package rhn_pkg;

	// Matrix geometry, scanned row-major.
	localparam int COLS = 16;
	localparam int ROWS = 16;

	// Scan counters hold values up to 255, enough for any geometry up to 256.
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(COLS - 1);
	localparam logic [CNT_W-1:0] ROW_LAST = CNT_W'(ROWS - 1);

	// Coordinates as they appear on the output word.
	localparam int COORD_W = 4;
	localparam logic [COORD_W-1:0] COL_OUT_LAST = COORD_W'(COLS - 1);
	localparam logic [COORD_W-1:0] ROW_OUT_LAST = COORD_W'(ROWS - 1);

	// Reseed constants.
	localparam logic [31:0] SEED_BASE = 32'hA53C9E1D;
	localparam logic [31:0] HASH_MUL  = 32'd2654435761;

	// Xorshift32 shift distances.
	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	// Brightness is VAL_BASE plus seven seed bits.
	localparam logic [7:0] VAL_BASE = 8'd80;
	localparam logic [7:0] VAL_TOP  = 8'd207;

	// Width of one hue sector and the hue value where each sector starts.
	localparam logic [7:0] HUE_SECTOR = 8'd43;

	// Colour wheel sectors, in order of rising hue.
	typedef enum logic [2:0] {
		RGN_RY = 3'd0,	// red to yellow
		RGN_YG = 3'd1,	// yellow to green
		RGN_GC = 3'd2,	// green to cyan
		RGN_CB = 3'd3,	// cyan to blue
		RGN_BM = 3'd4,	// blue to magenta
		RGN_MR = 3'd5	// magenta to red
	} rgn_t;

	// One 13/17/5 xorshift32 step.
	function automatic logic [31:0] xs_next(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		a = v ^ (v << XS_A);
		b = a ^ (a >> XS_B);
		return b ^ (b << XS_C);
	endfunction

endpackage

/* design/rhn_hsv.sv */
// ---------------------------------------------------------------------------
// rhn_hsv - HSV to RGB at full saturation
// Turns a hue sector, the position within it and a brightness into red, green
// and blue. The scaled ramps are divided by 255 with a shift-and-add form.
// ---------------------------------------------------------------------------
module rhn_hsv
	import rhn_pkg::*;
(
	input  rgn_t       region,
	input  logic [7:0] rem,
	input  logic [7:0] val,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	// Exact floor(x / 255) for every x below 65280.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

	logic [15:0] fall_prod;
	logic [15:0] rise_prod;
	logic [7:0]  q;
	logic [7:0]  t;

	assign fall_prod = {8'd0, val} * {8'd0, 8'd255 - rem};
	assign rise_prod = {8'd0, val} * {8'd0, rem};
	assign q = div255(fall_prod);
	assign t = div255(rise_prod);

	// The falling colour is q, the rising one t; the third channel is off.
	always_comb begin
		case (region)
			RGN_YG: begin red = q;    green = val;  blue = 8'd0; end
			RGN_GC: begin red = 8'd0; green = val;  blue = t;    end
			RGN_CB: begin red = 8'd0; green = q;    blue = val;  end
			RGN_BM: begin red = t;    green = 8'd0; blue = val;  end
			RGN_MR: begin red = val;  green = 8'd0; blue = q;    end
			default: begin red = val; green = t;    blue = 8'd0; end
		endcase
	end

endmodule

/* design/random_hue_noise_pixel_generator.sv */
// ---------------------------------------------------------------------------
// random_hue_noise_pixel_generator - noise pixel source for an LED matrix
// Each request word yields one pixel of random hue and random brightness.
// ---------------------------------------------------------------------------
// The slave channel takes one request word per pixel. tuser set marks the
// first pixel of a frame: the xorshift seed is rebuilt from the phase and the
// time carried in tdata, and the scan coordinates go back to the top left.
// Every word, the first of a frame included, steps the seed once; the pixel
// colour follows from the stepped seed. The master channel returns one pixel
// word per request with its column and row, and tlast on the last pixel of
// the frame. Until the first frame start the seed is zero and the pixels are
// dim red.
// The data path is four register stages deep: request register with the
// time hash multiplier in front of it, seed and scan stage, hue sector stage
// and the output register. One request is taken every cycle while results
// flow.
// Each stage moves on when it is empty or the one after it moves, so a
// stalled receiver holds the output word and the pipe fills up behind it
// before tready falls; requests are still taken while earlier stages have
// gaps. Reset empties the pipe, clears the seed and restarts the scan.
// ---------------------------------------------------------------------------
module random_hue_noise_pixel_generator
	import rhn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,	// frame_phase [31:0], time_ms [63:32]
	input  logic        s_axis_tuser,	// frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,	// red, green, blue, col, row from bit 0 up
	output logic        m_axis_tlast	// last_of_frame
);

	// Stage valid bits and advance conditions.
	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	logic adv1, adv2, adv3, adv_o;

	// Stage 1: request with the reseed value already formed.
	logic        start_s1;
	logic [31:0] reseed_s1;
	logic [31:0] reseed_d;

	// Stage 2: seed, scan position and colour controls.
	logic [31:0]      seed_q;
	logic [CNT_W-1:0] col_q, row_q;
	logic [31:0]      seed_d;
	logic [CNT_W-1:0] cur_col, cur_row, nxt_col, nxt_row;
	logic             cur_last;
	logic [7:0]       hue_s2, val_s2;
	logic [COORD_W-1:0] col_s2, row_s2;
	logic             last_s2;

	// Stage 3: hue sector and position inside it.
	rgn_t             rgn_d;
	logic [7:0]       sec_base;
	logic [5:0]       sec_off;
	rgn_t             rgn_s3;
	logic [7:0]       rem_s3, val_s3;
	logic [COORD_W-1:0] col_s3, row_s3;
	logic             last_s3;

	// Output register.
	logic [7:0]  red, green, blue;
	logic [31:0] tdata_q;
	logic        tlast_q;

	assign adv_o = !out_vld_q || m_axis_tready;
	assign adv3  = !vld_s3 || adv_o;
	assign adv2  = !vld_s2 || adv3;
	assign adv1  = !vld_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv1)  vld_s1    <= s_axis_tvalid;
			if (adv2)  vld_s2    <= vld_s1;
			if (adv3)  vld_s3    <= vld_s2;
			if (adv_o) out_vld_q <= vld_s3;
		end
	end

	// The time hash multiplier sits in front of the request register so that
	// the seed loop itself is only a multiplexer and an XOR network.
	assign reseed_d = SEED_BASE ^ s_axis_tdata[31:0] ^ (s_axis_tdata[63:32] * HASH_MUL);

	always_ff @(posedge clk) begin
		if (adv1) begin
			start_s1  <= s_axis_tuser;
			reseed_s1 <= reseed_d;
		end
	end

	// A frame start replaces the seed and the scan position before the step.
	assign seed_d   = xs_next(start_s1 ? reseed_s1 : seed_q);
	assign cur_col  = start_s1 ? '0 : col_q;
	assign cur_row  = start_s1 ? '0 : row_q;
	assign cur_last = (cur_col == COL_LAST) && (cur_row == ROW_LAST);

	always_comb begin
		nxt_col = cur_col + CNT_W'(1);
		nxt_row = cur_row;
		if (cur_col == COL_LAST) begin
			nxt_col = '0;
			nxt_row = (cur_row == ROW_LAST) ? '0 : cur_row + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (vld_s1 && adv2) begin
			seed_q <= seed_d;
			col_q  <= nxt_col;
			row_q  <= nxt_row;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			hue_s2  <= seed_d[31:24];
			val_s2  <= VAL_BASE + {1'b0, seed_d[14:8]};
			col_s2  <= cur_col[COORD_W-1:0];
			row_s2  <= cur_row[COORD_W-1:0];
			last_s2 <= cur_last;
		end
	end

	// Hue sector by comparison against the sector starts.
	always_comb begin
		if (hue_s2 >= 8'(5 * HUE_SECTOR)) begin
			rgn_d = RGN_MR; sec_base = 8'(5 * HUE_SECTOR);
		end else if (hue_s2 >= 8'(4 * HUE_SECTOR)) begin
			rgn_d = RGN_BM; sec_base = 8'(4 * HUE_SECTOR);
		end else if (hue_s2 >= 8'(3 * HUE_SECTOR)) begin
			rgn_d = RGN_CB; sec_base = 8'(3 * HUE_SECTOR);
		end else if (hue_s2 >= 8'(2 * HUE_SECTOR)) begin
			rgn_d = RGN_GC; sec_base = 8'(2 * HUE_SECTOR);
		end else if (hue_s2 >= HUE_SECTOR) begin
			rgn_d = RGN_YG; sec_base = HUE_SECTOR;
		end else begin
			rgn_d = RGN_RY; sec_base = 8'd0;
		end
	end

	// Offset within the sector is at most 42; times six stays below 256.
	logic [7:0] sec_diff;
	assign sec_diff = hue_s2 - sec_base;
	assign sec_off  = sec_diff[5:0];

	always_ff @(posedge clk) begin
		if (adv3) begin
			rgn_s3  <= rgn_d;
			rem_s3  <= {sec_off, 2'b00} + {1'b0, sec_off, 1'b0};
			val_s3  <= val_s2;
			col_s3  <= col_s2;
			row_s3  <= row_s2;
			last_s3 <= last_s2;
		end
	end

	rhn_hsv u_hsv (
		.region (rgn_s3),
		.rem    (rem_s3),
		.val    (val_s3),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	always_ff @(posedge clk) begin
		if (adv_o) begin
			tdata_q <= {row_s3, col_s3, blue, green, red};
			tlast_q <= last_s3;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

endmodule

/* design/rhn_checker.sv */
// ---------------------------------------------------------------------------
// rhn_checker - port level checks for the noise pixel generator
// Watches the stream ports of the top level and is attached to it by bind.
// ---------------------------------------------------------------------------
module rhn_checker
	import rhn_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,	// frame_phase [31:0], time_ms [63:32]
	input logic        s_axis_tuser,	// frame_start
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,	// red, green, blue, col, row from bit 0 up
	input logic        m_axis_tlast	// last_of_frame
);

	logic [7:0] red, green, blue;
	logic [COORD_W-1:0] col, row;

	assign red   = m_axis_tdata[7:0];
	assign green = m_axis_tdata[15:8];
	assign blue  = m_axis_tdata[23:16];
	assign col   = m_axis_tdata[27:24];
	assign row   = m_axis_tdata[31:28];

	// A stalled pixel word stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("pixel word changed while stalled");

	// With the output free the whole pipe moves, so requests are taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("request refused while the output could move");

	// The end of frame flag only comes with the bottom right coordinates.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> col == COL_OUT_LAST && row == ROW_OUT_LAST)
		else $error("end of frame flag away from the last pixel");

	// At full saturation one channel is always dark.
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> red == 8'd0 || green == 8'd0 || blue == 8'd0)
		else $error("no dark channel in a saturated pixel");

	// The brightest channel carries the brightness, which has a fixed range.
	a_bright: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(red >= VAL_BASE && red <= VAL_TOP) ||
			(green >= VAL_BASE && green <= VAL_TOP) ||
			(blue >= VAL_BASE && blue <= VAL_TOP))
		else $error("pixel brightness out of range");

endmodule

bind random_hue_noise_pixel_generator rhn_checker u_rhn_checker (.*);
